FILE: design/cht_pkg.sv
// Package for the chained hash symbol table.
// Holds the sequencer state type, op and register codes, name constants and name_clean.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_HEADW,
    S_CHK,
    S_CMP,
    S_ENTER,
    S_LINK,
    S_ATTR,
    S_SWRD,
    S_SWWR,
    S_DONE
  } cht_state_t;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ENTER  = 2'd1;
  localparam logic [1:0] OP_ATTR   = 2'd2;
  localparam logic [1:0] OP_RESET  = 2'd3;

  localparam logic [1:0] CFG_REV_EN   = 2'd0;
  localparam logic [1:0] CFG_OPC_CODE = 2'd1;
  localparam logic [1:0] CFG_REV_MASK = 2'd2;

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam int NAME_BYTES = 8;

  // keep bytes up to the first zero byte
  function automatic logic [63:0] name_clean(input logic [63:0] n);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (n[8*i +: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[8*i +: 8] = n[8*i +: 8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/cht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/chained_hash_symbol_table.sv
// Symbol table of 8-byte names with per-bucket chains held in synchronous RAMs.
// Uses cht_pkg and cht_ram.
//
// One request at a time. After reset the bucket heads are cleared, one bucket per
// cycle, with in_stall high. A lookup or enter first computes the bucket
// (reciprocal multiply, then multiply back and subtract), then reads the bucket
// head and walks the chain link by link to a hit or to the chain end; an enter
// that misses then appends a new entry, and finally the result is handed over.
// An attribute write updates an existing entry's kind and value; a local-name reset
// reads each stored entry name and writes back with '~' those whose low byte is '1'.
// A finished result sits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_symbol_table
  import cht_pkg::*;
#(
  parameter int HASH_BUCKETS = 199,
  parameter int MAX_ENTRIES  = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [15:0]                     cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_op,
  input  wire logic                            in_want_opcode,
  input  wire logic [31:0]                     in_name_lo,
  input  wire logic [31:0]                     in_name_hi,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0]  in_target_index,
  input  wire logic [15:0]                     in_new_type,
  input  wire logic [31:0]                     in_new_value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_found,
  output logic                                 out_entry_valid,
  output logic [$clog2(MAX_ENTRIES)-1:0]       out_entry_index,
  output logic [15:0]                          out_entry_type,
  output logic [31:0]                          out_entry_value,
  output logic                                 out_status
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int PTR_W = $clog2(MAX_ENTRIES + 1);
  localparam int BKT_W = $clog2(HASH_BUCKETS);
  localparam int RW    = BKT_W + 1;
  localparam int RSH   = 32 + $clog2(HASH_BUCKETS);
  localparam logic [32:0] RCP =
    33'(((65'd1 << RSH) + 65'(HASH_BUCKETS - 1)) / 65'(HASH_BUCKETS));
  localparam logic [PTR_W-1:0] NO_ENTRY = PTR_W'(MAX_ENTRIES);
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(HASH_BUCKETS - 1);

  cht_state_t state_r, state_nxt;

  logic             rev_en_r;
  logic [15:0]      opc_code_r, rev_mask_r;
  logic [1:0]       op_r;
  logic             want_r;
  logic [63:0]      key_r;
  logic [31:0]      sum_r;
  logic [64:0]      prod_r;
  logic [IDX_W-1:0] tgt_r;
  logic [15:0]      ntype_r;
  logic [31:0]      nval_r;
  logic [RW-1:0]    rem_r;
  logic [2:0]       hcnt_r;
  logic [BKT_W-1:0] clr_r;
  logic [PTR_W-1:0] idx_r, tail_r, cnt_r;
  logic             tail_ok_r;

  logic             res_found_r, res_valid_r, res_status_r;
  logic [IDX_W-1:0] res_idx_r;
  logic [15:0]      res_type_r;
  logic [31:0]      res_value_r;

  logic             out_valid_r, out_found_r, out_ev_r, out_status_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [15:0]      out_type_r;
  logic [31:0]      out_value_r;

  logic                 bh_we;
  logic [BKT_W-1:0]     bh_waddr;
  logic [PTR_W-1:0]     bh_wdata, bh_rdata;
  logic                 nm_we, kd_we, wd_we, nx_we;
  logic [IDX_W-1:0]     nm_waddr, kd_waddr, wd_waddr, nx_waddr, e_raddr;
  logic [63:0]          nm_wdata, nm_rdata;
  logic [15:0]          kd_wdata, kd_rdata;
  logic [31:0]          wd_wdata, wd_rdata;
  logic [PTR_W-1:0]     nx_wdata, nx_rdata;

  logic             in_acc, cur_live, hit, out_load;
  logic [RW-1:0]    rem_nxt;
  logic [31:0]      quo, qmul, rdiff;
  logic [15:0]      hit_kind, new_kind;
  logic [63:0]      stored_name;

  assign in_acc   = in_valid && !in_stall;
  assign cur_live = idx_r < cnt_r;
  assign hit      = (nm_rdata == key_r) &&
                    ((kd_rdata == opc_code_r) == (op_r == OP_LOOKUP && want_r));
  assign hit_kind = rev_en_r ? (kd_rdata | rev_mask_r) : kd_rdata;
  assign new_kind = rev_en_r ? rev_mask_r : 16'h0000;
  assign stored_name = (key_r[7:0] == CH_TILDE) ? {key_r[63:8], CH_ONE} : key_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // bucket = sum - floor(sum * RCP >> RSH) * HASH_BUCKETS
  assign quo     = 32'(prod_r >> RSH);
  assign qmul    = quo * 32'(HASH_BUCKETS);
  assign rdiff   = sum_r - qmul;
  assign rem_nxt = rdiff[RW-1:0];

  cht_ram #(.WIDTH(PTR_W), .DEPTH(HASH_BUCKETS)) u_head (
    .clk, .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(rem_r[BKT_W-1:0]), .rdata(bh_rdata));
  cht_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_name (
    .clk, .we(nm_we), .waddr(nm_waddr), .wdata(nm_wdata),
    .raddr(e_raddr), .rdata(nm_rdata));
  cht_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_kind (
    .clk, .we(kd_we), .waddr(kd_waddr), .wdata(kd_wdata),
    .raddr(e_raddr), .rdata(kd_rdata));
  cht_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_word (
    .clk, .we(wd_we), .waddr(wd_waddr), .wdata(wd_wdata),
    .raddr(e_raddr), .rdata(wd_rdata));
  cht_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ENTRIES)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(e_raddr), .rdata(nx_rdata));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == LAST_BKT) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_ATTR:  state_nxt = S_ATTR;
            OP_RESET: state_nxt = S_SWRD;
            default:  state_nxt = S_HASH;
          endcase
        end
      end
      S_HASH:  if (hcnt_r == 3'd1) state_nxt = S_HEAD;
      S_HEAD:  state_nxt = S_HEADW;
      S_HEADW: state_nxt = S_CHK;
      S_CHK: begin
        if (cur_live) state_nxt = S_CMP;
        else if (op_r == OP_ENTER && cnt_r != NO_ENTRY) state_nxt = S_ENTER;
        else state_nxt = S_DONE;
      end
      S_CMP:   state_nxt = hit ? S_DONE : S_CHK;
      S_ENTER: state_nxt = S_LINK;
      S_LINK:  state_nxt = S_DONE;
      S_ATTR:  state_nxt = S_DONE;
      S_SWRD:  state_nxt = cur_live ? S_SWWR : S_DONE;
      S_SWWR:  state_nxt = S_SWRD;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = (state_r != S_IDLE);
    e_raddr  = idx_r[IDX_W-1:0];
    bh_we = 1'b0; bh_waddr = clr_r; bh_wdata = NO_ENTRY;
    nm_we = 1'b0; nm_waddr = idx_r[IDX_W-1:0]; nm_wdata = stored_name;
    kd_we = 1'b0; kd_waddr = idx_r[IDX_W-1:0]; kd_wdata = hit_kind;
    wd_we = 1'b0; wd_waddr = tgt_r; wd_wdata = nval_r;
    nx_we = 1'b0; nx_waddr = cnt_r[IDX_W-1:0]; nx_wdata = NO_ENTRY;
    unique case (state_r)
      S_CLEAR: bh_we = 1'b1;
      S_CMP: begin
        if (hit) begin
          kd_we = 1'b1;
          nm_we = (nm_rdata[7:0] == CH_TILDE);
        end
      end
      S_ENTER: begin
        nm_we = 1'b1; nm_waddr = cnt_r[IDX_W-1:0];
        kd_we = 1'b1; kd_waddr = cnt_r[IDX_W-1:0]; kd_wdata = new_kind;
        wd_we = 1'b1; wd_waddr = cnt_r[IDX_W-1:0]; wd_wdata = '0;
        nx_we = 1'b1;
      end
      S_LINK: begin
        if (tail_ok_r) begin
          nx_we = 1'b1; nx_waddr = tail_r[IDX_W-1:0]; nx_wdata = cnt_r;
        end else begin
          bh_we = 1'b1; bh_waddr = rem_r[BKT_W-1:0]; bh_wdata = cnt_r;
        end
      end
      S_ATTR: begin
        if (PTR_W'(tgt_r) < cnt_r) begin
          kd_we = 1'b1; kd_waddr = tgt_r; kd_wdata = ntype_r;
          wd_we = 1'b1;
        end
      end
      S_SWWR: begin
        nm_we    = (nm_rdata[7:0] == CH_ONE);
        nm_wdata = {nm_rdata[63:8], CH_TILDE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      rev_en_r    <= 1'b0;
      opc_code_r  <= 16'h0001;
      rev_mask_r  <= 16'h8000;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REV_EN:   rev_en_r   <= cfg_wdata[0];
          CFG_OPC_CODE: opc_code_r <= cfg_wdata;
          CFG_REV_MASK: rev_mask_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_LINK) cnt_r <= cnt_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_op;
      want_r  <= in_want_opcode;
      key_r   <= name_clean({in_name_hi, in_name_lo});
      sum_r   <= in_name_lo + in_name_hi;
      tgt_r   <= in_target_index;
      ntype_r <= in_new_type;
      nval_r  <= in_new_value;
      rem_r   <= '0;
      hcnt_r  <= '0;
      idx_r   <= '0;
      tail_ok_r    <= 1'b0;
      res_found_r  <= 1'b0;
      res_valid_r  <= 1'b0;
      res_status_r <= 1'b0;
      res_idx_r    <= '0;
      res_type_r   <= '0;
      res_value_r  <= '0;
    end
    case (state_r)
      S_HASH: begin
        if (hcnt_r == 3'd0) prod_r <= {33'd0, sum_r} * {32'd0, RCP};
        else rem_r <= rem_nxt;
        hcnt_r <= hcnt_r + 1'b1;
      end
      S_HEADW: idx_r <= bh_rdata;
      S_CHK: if (!cur_live && op_r == OP_ENTER && cnt_r == NO_ENTRY) res_status_r <= 1'b1;
      S_CMP: begin
        if (hit) begin
          res_found_r <= 1'b1;
          res_valid_r <= 1'b1;
          res_idx_r   <= idx_r[IDX_W-1:0];
          res_type_r  <= hit_kind;
          res_value_r <= wd_rdata;
        end else begin
          tail_r    <= idx_r;
          tail_ok_r <= 1'b1;
          idx_r     <= nx_rdata;
        end
      end
      S_ENTER: begin
        res_valid_r <= 1'b1;
        res_idx_r   <= cnt_r[IDX_W-1:0];
        res_type_r  <= new_kind;
      end
      S_ATTR: begin
        if (PTR_W'(tgt_r) < cnt_r) begin
          res_valid_r <= 1'b1;
          res_idx_r   <= tgt_r;
          res_type_r  <= ntype_r;
          res_value_r <= nval_r;
        end
      end
      S_SWWR: idx_r <= idx_r + 1'b1;
      default: ;
    endcase
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_ev_r     <= res_valid_r;
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_type_r   <= res_type_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_entry_valid = out_ev_r;
  assign out_entry_index = out_idx_r;
  assign out_entry_type  = out_type_r;
  assign out_entry_value = out_value_r;
  assign out_status      = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NO_ENTRY) else $error("entry count over capacity");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE)) else $error("request without result");
  a_full_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> !out_ev_r) else $error("refused enter with entry");
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall) else $error("request taken during clear");

endmodule
`default_nettype wire
